FILE: hw/rtl/csvg_pkg.sv
// shared constants and types for the cube-sphere vertex generator
package csvg_pkg;

  localparam int MAX_GRID_EDGE = 64;
  localparam int MIN_GRID_EDGE = 2;
  localparam int NORM_BITS     = 20;

  localparam int EDGE_W   = 7;
  localparam int RADIUS_W = 24;
  localparam int COORD_W  = 8;
  localparam int SUMSQ_W  = 16;
  localparam int CELL_W   = 13;
  localparam int INDEX_W  = 15;
  localparam int POS_W    = 26;
  localparam int FACE_W   = 3;
  localparam int LEN_W    = 28;

  localparam logic [FACE_W-1:0] FACE_FIRST = 3'd0;
  localparam logic [FACE_W-1:0] FACE_LAST  = 3'd5;

  localparam logic [0:0] REG_GRID_EDGE = 1'b0;
  localparam logic [0:0] REG_RADIUS    = 1'b1;

  // one classified grid point waiting for the arithmetic core
  typedef struct packed {
    logic                       outside;
    logic signed [COORD_W-1:0]  a;
    logic signed [COORD_W-1:0]  b;
    logic signed [COORD_W-1:0]  c;
    logic [SUMSQ_W-1:0]         sumsq;
    logic [CELL_W-1:0]          base;
    logic [CELL_W-1:0]          per_face;
  } job_t;

  // scaled coordinates of one grid point, ready for the six faces
  typedef struct packed {
    logic                       outside;
    logic signed [POS_W-1:0]    px;
    logic signed [POS_W-1:0]    py;
    logic signed [POS_W-1:0]    pz;
    logic [CELL_W-1:0]          base;
    logic [CELL_W-1:0]          per_face;
  } point_t;

endpackage

FILE: hw/rtl/csvg_if.sv
// item channels: grid points in, vertices out
interface csvg_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] grid_row;
  logic [5:0] grid_col;
  modport source (output valid, grid_row, grid_col, input ready);
  modport sink (input valid, grid_row, grid_col, output ready);
endinterface

interface csvg_out_if;
  logic                               valid;
  logic                               ready;
  logic [csvg_pkg::FACE_W-1:0]        face_number;
  logic [csvg_pkg::INDEX_W-1:0]       vertex_index;
  logic signed [csvg_pkg::POS_W-1:0]  pos_x;
  logic signed [csvg_pkg::POS_W-1:0]  pos_y;
  logic signed [csvg_pkg::POS_W-1:0]  pos_z;
  logic                               out_of_grid;
  logic                               last_face;
  modport source (output valid, face_number, vertex_index, pos_x, pos_y, pos_z,
                  out_of_grid, last_face, input ready);
  modport sink (input valid, face_number, vertex_index, pos_x, pos_y, pos_z,
                out_of_grid, last_face, output ready);
  modport mon (input valid, ready, face_number, vertex_index, pos_x, pos_y, pos_z,
               out_of_grid, last_face);
endinterface

FILE: hw/rtl/csvg_queue.sv
// two-entry job queue between the front end and the arithmetic core
module csvg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csvg_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output csvg_pkg::job_t rdata,
  output logic           empty
);

  csvg_pkg::job_t mem [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        mem[wptr] <= wdata;
        wptr      <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/csvg_front.sv
// front end: takes grid points, checks them against the grid and forms the integer vector
module csvg_front (
  input  logic                          clk,
  input  logic                          rst,
  csvg_in_if.sink                       grid,
  input  logic [csvg_pkg::EDGE_W-1:0]   grid_edge,
  output logic                          push,
  output csvg_pkg::job_t                job,
  input  logic                          full
);

  logic [csvg_pkg::EDGE_W-1:0]       n_eff;
  logic [5:0]                        m;
  logic signed [15:0]                sq_a;
  logic signed [15:0]                sq_b;
  logic signed [15:0]                sq_c;
  logic [17:0]                       sum;
  logic [13:0]                       lin_idx;
  logic [13:0]                       nn;
  logic                              seen;

  always_comb begin
    if (grid_edge < csvg_pkg::EDGE_W'(csvg_pkg::MIN_GRID_EDGE)) begin
      n_eff = csvg_pkg::EDGE_W'(csvg_pkg::MIN_GRID_EDGE);
    end else if (grid_edge > csvg_pkg::EDGE_W'(csvg_pkg::MAX_GRID_EDGE)) begin
      n_eff = csvg_pkg::EDGE_W'(csvg_pkg::MAX_GRID_EDGE);
    end else begin
      n_eff = grid_edge;
    end
    m = 6'(n_eff - 7'd1);
    // point scaled by N-1: (2i-M, 2j-M, M)
    job.a = $signed({1'b0, grid.grid_row, 1'b0}) - $signed({2'b00, m});
    job.b = $signed({1'b0, grid.grid_col, 1'b0}) - $signed({2'b00, m});
    job.c = $signed({2'b00, m});
    sq_a  = job.a * job.a;
    sq_b  = job.b * job.b;
    sq_c  = job.c * job.c;
    sum   = 18'(sq_a) + 18'(sq_b) + 18'(sq_c);
    job.sumsq = sum[csvg_pkg::SUMSQ_W-1:0];
    lin_idx = ({8'd0, grid.grid_row} * {7'd0, n_eff}) + {8'd0, grid.grid_col};
    nn      = {7'd0, n_eff} * {7'd0, n_eff};
    job.base     = lin_idx[csvg_pkg::CELL_W-1:0];
    job.per_face = nn[csvg_pkg::CELL_W-1:0];
    job.outside  = ({1'b0, grid.grid_row} >= n_eff) || ({1'b0, grid.grid_col} >= n_eff);
  end

  assign grid.ready = seen && !full;
  assign push       = grid.valid && grid.ready;

  // hold off taking items for the cycle that reset is released
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else begin
      seen <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/csvg_back.sv
// arithmetic core: square root of the squared length, then three rounded divisions
module csvg_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [csvg_pkg::RADIUS_W-1:0]  radius,
  input  logic                           empty,
  input  csvg_pkg::job_t                 job,
  output logic                           pop,
  output logic                           res_valid,
  input  logic                           res_ready,
  output csvg_pkg::point_t               res
);

  typedef enum logic [2:0] {IDLE, SQRT, MUL, DSET, DIV, DONE} state_t;

  state_t                            state;
  csvg_pkg::job_t                    cur;
  logic [3:0]                        cnt;
  logic [1:0]                        k;
  logic [15:0]                       vsh;
  logic [29:0]                       srem;
  logic [csvg_pkg::LEN_W-1:0]        root;
  logic [csvg_pkg::LEN_W-1:0]        len;
  logic [30:0]                       prod;
  logic [28:0]                       drem;
  logic [25:0]                       dsh;
  logic [25:0]                       quo;
  logic signed [csvg_pkg::POS_W-1:0] crd [3];

  logic [29:0]                       srem_next;
  logic [csvg_pkg::LEN_W-1:0]        root_next;
  logic [28:0]                       drem_next;
  logic [25:0]                       quo_next;
  logic signed [csvg_pkg::COORD_W-1:0] sel;
  logic [6:0]                        mag;
  logic [52:0]                       dd;
  logic [25:0]                       qclip;
  logic [28:0]                       dvs;

  // two square root digits per cycle
  always_comb begin
    logic [31:0] t;
    logic [31:0] trial;
    logic [15:0] v;
    srem_next = srem;
    root_next = root;
    v         = vsh;
    for (int i = 0; i < 2; i++) begin
      t     = {srem_next, v[15:14]};
      trial = {2'b00, root_next, 2'b01};
      if (t >= trial) begin
        srem_next = 30'(t - trial);
        root_next = {root_next[csvg_pkg::LEN_W-2:0], 1'b1};
      end else begin
        srem_next = t[29:0];
        root_next = {root_next[csvg_pkg::LEN_W-2:0], 1'b0};
      end
      v = {v[13:0], 2'b00};
    end
  end

  // two quotient bits per cycle
  assign dvs = {len, 1'b0};
  always_comb begin
    logic [29:0] t;
    logic [25:0] s;
    drem_next = drem;
    quo_next  = quo;
    s         = dsh;
    for (int i = 0; i < 2; i++) begin
      t = {drem_next, s[25]};
      if (t >= {1'b0, dvs}) begin
        drem_next = 29'(t - {1'b0, dvs});
        quo_next  = {quo_next[24:0], 1'b1};
      end else begin
        drem_next = t[28:0];
        quo_next  = {quo_next[24:0], 1'b0};
      end
      s = {s[24:0], 1'b0};
    end
  end

  always_comb begin
    unique case (k)
      2'd0:    sel = cur.a;
      2'd1:    sel = cur.b;
      default: sel = cur.c;
    endcase
    mag   = sel[csvg_pkg::COORD_W-1] ? 7'(-sel) : sel[6:0];
    // round half away: (2*num + len) / (2*len)
    dd    = {1'b0, prod, 21'd0} + {25'd0, len};
    qclip = (quo_next > {2'b00, radius}) ? {2'b00, radius} : quo_next;
  end

  assign pop          = (state == IDLE) && !empty;
  assign res_valid    = (state == DONE);
  assign res.outside  = cur.outside;
  assign res.px       = crd[0];
  assign res.py       = crd[1];
  assign res.pz       = crd[2];
  assign res.base     = cur.base;
  assign res.per_face = cur.per_face;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= 4'd0;
      k     <= 2'd0;
    end else begin
      unique case (state)
        IDLE: begin
          if (!empty) begin
            cur   <= job;
            vsh   <= job.sumsq;
            srem  <= 30'd0;
            root  <= '0;
            cnt   <= 4'd13;
            state <= SQRT;
          end
        end
        SQRT: begin
          srem <= srem_next;
          root <= root_next;
          vsh  <= {vsh[11:0], 4'd0};
          cnt  <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            len   <= root_next;
            k     <= 2'd0;
            state <= MUL;
          end
        end
        MUL: begin
          prod  <= {7'd0, radius} * {24'd0, mag};
          state <= DSET;
        end
        DSET: begin
          drem  <= {2'b00, dd[52:26]};
          dsh   <= dd[25:0];
          quo   <= 26'd0;
          cnt   <= 4'd12;
          state <= DIV;
        end
        DIV: begin
          drem <= drem_next;
          quo  <= quo_next;
          dsh  <= {dsh[23:0], 2'b00};
          cnt  <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            crd[k] <= sel[csvg_pkg::COORD_W-1] ? -$signed(qclip) : $signed(qclip);
            if (k == 2'd2) begin
              state <= DONE;
            end else begin
              k     <= k + 2'd1;
              state <= MUL;
            end
          end
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/csvg_emit.sv
// back end: sends six face vertices per point, one per cycle while ready
module csvg_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  output logic             res_ready,
  input  csvg_pkg::point_t res,
  csvg_out_if.source       vertex
);

  csvg_pkg::point_t              set;
  logic                          busy;
  logic [csvg_pkg::FACE_W-1:0]   face;
  logic [csvg_pkg::INDEX_W-1:0]  idx;
  logic                          fire;
  logic signed [csvg_pkg::POS_W-1:0] vx;
  logic signed [csvg_pkg::POS_W-1:0] vy;
  logic signed [csvg_pkg::POS_W-1:0] vz;

  assign fire      = vertex.valid && vertex.ready;
  assign res_ready = !busy || (fire && face == csvg_pkg::FACE_LAST);

  always_comb begin
    unique case (face)
      3'd0:    begin vx = set.px;  vy = set.py;  vz = -set.pz; end
      3'd1:    begin vx = set.px;  vy = set.py;  vz = set.pz;  end
      3'd2:    begin vx = set.px;  vy = set.pz;  vz = set.py;  end
      3'd3:    begin vx = set.px;  vy = -set.pz; vz = set.py;  end
      3'd4:    begin vx = -set.pz; vy = set.px;  vz = set.py;  end
      default: begin vx = set.pz;  vy = set.px;  vz = set.py;  end
    endcase
  end

  assign vertex.valid        = busy;
  assign vertex.face_number  = face;
  assign vertex.out_of_grid  = set.outside;
  assign vertex.last_face    = (face == csvg_pkg::FACE_LAST);
  assign vertex.vertex_index = set.outside ? '0 : idx;
  assign vertex.pos_x        = set.outside ? '0 : vx;
  assign vertex.pos_y        = set.outside ? '0 : vy;
  assign vertex.pos_z        = set.outside ? '0 : vz;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      face <= csvg_pkg::FACE_FIRST;
    end else begin
      // a new point is only taken when idle or on the last face going out
      if (res_valid && res_ready) begin
        set  <= res;
        busy <= 1'b1;
        face <= csvg_pkg::FACE_FIRST;
        idx  <= {2'b00, res.base};
      end else if (fire) begin
        if (face == csvg_pkg::FACE_LAST) begin
          busy <= 1'b0;
        end else begin
          face <= face + 3'd1;
          idx  <= idx + {2'b00, set.per_face};
        end
      end
    end
  end

endmodule

FILE: hw/rtl/cube_sphere_vertex_gen_top.sv
// top level of the cube-sphere grid vertex generator
// Each grid point (row, column) becomes six sphere vertices, one per cube face,
// sent one per cycle while the receiver is ready, with face 5 marked last. The
// front end takes a point in any cycle that its two-entry queue has room; the
// arithmetic core then forms the square root at two digits a cycle and three
// rounded divisions at two quotient bits a cycle. That shared iterative core
// works on one point at a time and takes no new point until the last is handed on.
// The six results of one point go out while the core already works on the next.
// Configuration is written through cfg_wr_en / cfg_addr / cfg_wdata: index 0 is
// the grid edge N (clamped to 2..64), index 1 the Q8.16 radius; write only while
// no point is in flight.
module cube_sphere_vertex_gen_top (
  input  logic                            clk,
  input  logic                            rst,
  csvg_in_if.sink                         grid,
  csvg_out_if.source                      vertex,
  input  logic                            cfg_wr_en,
  input  logic [0:0]                      cfg_addr,
  input  logic [csvg_pkg::RADIUS_W-1:0]   cfg_wdata
);

  logic [csvg_pkg::EDGE_W-1:0]    grid_edge;
  logic [csvg_pkg::RADIUS_W-1:0]  radius;
  logic                           push;
  logic                           full;
  logic                           pop;
  logic                           empty;
  csvg_pkg::job_t                 job_in;
  csvg_pkg::job_t                 job_out;
  logic                           res_valid;
  logic                           res_ready;
  csvg_pkg::point_t               res;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_edge <= csvg_pkg::EDGE_W'(16);
      radius    <= csvg_pkg::RADIUS_W'(65536);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        csvg_pkg::REG_GRID_EDGE: grid_edge <= cfg_wdata[csvg_pkg::EDGE_W-1:0];
        csvg_pkg::REG_RADIUS:    radius    <= cfg_wdata;
        default:                 radius    <= radius;
      endcase
    end
  end

  csvg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .grid      (grid),
    .grid_edge (grid_edge),
    .push      (push),
    .job       (job_in),
    .full      (full)
  );

  csvg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (pop),
    .rdata (job_out),
    .empty (empty)
  );

  csvg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .radius    (radius),
    .empty     (empty),
    .job       (job_out),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  csvg_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .vertex    (vertex)
  );

endmodule

FILE: hw/rtl/csvg_checker.sv
// port-level checks on the vertex output, bound to the top level
module csvg_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               valid,
  input  logic                               ready,
  input  logic [csvg_pkg::FACE_W-1:0]        face_number,
  input  logic [csvg_pkg::INDEX_W-1:0]       vertex_index,
  input  logic signed [csvg_pkg::POS_W-1:0]  pos_x,
  input  logic signed [csvg_pkg::POS_W-1:0]  pos_y,
  input  logic signed [csvg_pkg::POS_W-1:0]  pos_z,
  input  logic                               out_of_grid,
  input  logic                               last_face
);

  logic fire;
  assign fire = valid && ready;

  a_last_is_face5: assert property (@(posedge clk) disable iff (rst)
    valid && last_face |-> face_number == csvg_pkg::FACE_LAST)
    else $error("last_face on a face other than five");

  a_face_steps: assert property (@(posedge clk) disable iff (rst)
    fire && !last_face |=>
      valid && face_number == $past(face_number) + 3'd1)
    else $error("faces of one point not sent in order");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    valid && out_of_grid |->
      vertex_index == '0 && pos_x == '0 && pos_y == '0 && pos_z == '0)
    else $error("point outside the grid carries data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=>
      valid && $stable(face_number) && $stable(vertex_index) &&
      $stable(pos_x) && $stable(pos_y) && $stable(pos_z))
    else $error("stalled item changed");

endmodule

bind cube_sphere_vertex_gen_top csvg_checker u_csvg_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (vertex.valid),
  .ready        (vertex.ready),
  .face_number  (vertex.face_number),
  .vertex_index (vertex.vertex_index),
  .pos_x        (vertex.pos_x),
  .pos_y        (vertex.pos_y),
  .pos_z        (vertex.pos_z),
  .out_of_grid  (vertex.out_of_grid),
  .last_face    (vertex.last_face)
);

FILE: bench/csvg_tb_if.sv
`timescale 1ns / 1ps
// shared bench types for the vertex generator checks
package csvg_tb_pkg;
  typedef struct {
    logic [2:0]         face;
    logic [14:0]        index;
    logic signed [25:0] x;
    logic signed [25:0] y;
    logic signed [25:0] z;
    logic               outside;
    logic               last;
  } vertex_t;
endpackage

FILE: bench/cube_sphere_vertex_gen_top_tb.sv
`timescale 1ns / 1ps
// self-checking bench: grid points in, six predicted sphere vertices checked per point
module cube_sphere_vertex_gen_top_tb;

  localparam int LIMIT = 2000000;
  localparam int N_RAND = 390;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [0:0] cfg_addr = csvg_pkg::REG_GRID_EDGE;
  logic [csvg_pkg::RADIUS_W-1:0] cfg_wdata = '0;

  csvg_in_if grid ();
  csvg_out_if vertex ();

  cube_sphere_vertex_gen_top dut (
    .clk(clk), .rst(rst), .grid(grid.sink), .vertex(vertex.source),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    grid.valid = 1'b0;
    grid.grid_row = '0;
    grid.grid_col = '0;
    vertex.ready = 1'b0;
  end

  initial begin
    forever #1 clk = ~clk;
  end

  // bench copy of the registers
  logic [6:0] edge_reg;
  logic [23:0] radius_reg;

  csvg_tb_pkg::vertex_t pending_vertices[$];
  int errors = 0;
  int vertices_seen = 0;
  int points_sent = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_off = 0;
  longint unsigned cycles = 0;

  int rows_edges[8] = '{2, 64, 0, 1, 127, 65, 3, 9};
  logic [23:0] radii[8] = '{24'hFFFFFF, 24'd0, 24'd1, 24'h7FFFFF, 24'd65536, 24'h123456,
                            24'd300000, 24'hFFFFFF};

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint scaled_coord(longint a, longint unsigned len,
                                          longint unsigned rad);
    longint unsigned mag, num, q;
    mag = (a < 0) ? -a : a;
    num = (rad * mag) << csvg_pkg::NORM_BITS;
    q = (2 * num + len) / (2 * len);
    if (q > rad) q = rad;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_vertices(logic [5:0] row_in, logic [5:0] col_in);
    longint n, row, col, m, a, b, c, px, py, pz, vx, vy, vz;
    longint unsigned s, len;
    bit outside;
    csvg_tb_pkg::vertex_t v;
    n = edge_reg;
    if (n < csvg_pkg::MIN_GRID_EDGE) n = csvg_pkg::MIN_GRID_EDGE;
    if (n > csvg_pkg::MAX_GRID_EDGE) n = csvg_pkg::MAX_GRID_EDGE;
    row = row_in;
    col = col_in;
    outside = (row >= n) || (col >= n);
    m = n - 1;
    a = 2 * row - m;
    b = 2 * col - m;
    c = m;
    s = a * a + b * b + c * c;
    len = int_sqrt(s << (2 * csvg_pkg::NORM_BITS));
    px = scaled_coord(a, len, radius_reg);
    py = scaled_coord(b, len, radius_reg);
    pz = scaled_coord(c, len, radius_reg);
    for (int f = 0; f < 6; f++) begin
      case (f)
        0: begin vx = px; vy = py; vz = -pz; end
        1: begin vx = px; vy = py; vz = pz; end
        2: begin vx = px; vy = pz; vz = py; end
        3: begin vx = px; vy = -pz; vz = py; end
        4: begin vx = -pz; vy = px; vz = py; end
        default: begin vx = pz; vy = px; vz = py; end
      endcase
      v.face = 3'(f);
      v.outside = outside;
      v.last = (f == csvg_pkg::FACE_LAST);
      if (outside) begin
        v.index = '0; v.x = '0; v.y = '0; v.z = '0;
      end else begin
        v.index = 15'(f * n * n + row * n + col);
        v.x = 26'(vx); v.y = 26'(vy); v.z = 26'(vz);
      end
      pending_vertices.push_back(v);
    end
  endtask

  // point off the grid: six vertices with zero data and out_of_grid set
  task automatic expect_outside();
    csvg_tb_pkg::vertex_t v;
    for (int f = 0; f < 6; f++) begin
      v.face = 3'(f);
      v.index = '0;
      v.x = '0;
      v.y = '0;
      v.z = '0;
      v.outside = 1'b1;
      v.last = (f == csvg_pkg::FACE_LAST);
      pending_vertices.push_back(v);
    end
  endtask

  task automatic write_reg(logic [0:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == csvg_pkg::REG_GRID_EDGE) edge_reg = val[6:0];
    else radius_reg = val;
  endtask

  // wait until every vertex has drained, then a margin for the core
  task automatic drain();
    grid.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // called at a rising edge; leaves valid high so items can follow back to back
  task automatic send_point(logic [5:0] row, logic [5:0] col, bit typed = 1'b0);
    while (send_idle && ($urandom_range(99) < 38)) begin
      grid.valid <= 1'b0;
      @(posedge clk);
    end
    grid.valid <= 1'b1;
    grid.grid_row <= row;
    grid.grid_col <= col;
    if (typed) expect_outside();
    else predict_vertices(row, col);
    do @(posedge clk); while (!grid.ready);
    points_sent++;
  endtask

  // receiver: random stalls, long hold-off when asked
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      vertex.ready <= 1'b0;
    end else begin
      vertex.ready <= recv_idle ? ($urandom_range(99) >= 38) : 1'b1;
    end
  end

  always @(posedge clk) begin
    csvg_tb_pkg::vertex_t e;
    if (!rst && vertex.valid && vertex.ready) begin
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        errors++;
        $display("%0t: expected no vertex, got face %0d", $time, vertex.face_number);
      end else begin
        e = pending_vertices.pop_front();
        if (e.face !== vertex.face_number || e.index !== vertex.vertex_index ||
            e.x !== vertex.pos_x || e.y !== vertex.pos_y || e.z !== vertex.pos_z ||
            e.outside !== vertex.out_of_grid || e.last !== vertex.last_face) begin
          errors++;
          $display("%0t: expected f%0d i%0d (%0d,%0d,%0d) o%0d l%0d",
                   $time, e.face, e.index, e.x, e.y, e.z, e.outside, e.last);
          $display("    got f%0d i%0d (%0d,%0d,%0d) o%0d l%0d",
                   vertex.face_number, vertex.vertex_index, vertex.pos_x, vertex.pos_y,
                   vertex.pos_z, vertex.out_of_grid, vertex.last_face);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  typedef struct {
    logic [5:0] row;
    logic [5:0] col;
    bit         typed;
  } point_row_t;

  // directed points under reset settings (N=16, radius 1.0); typed rows lie off the grid
  point_row_t directed[] = '{
    '{0, 0, 0}, '{15, 15, 0}, '{0, 15, 0}, '{15, 0, 0}, '{7, 8, 0}, '{8, 7, 0},
    '{16, 0, 1}, '{0, 16, 1}, '{63, 63, 1}, '{42, 21, 1}, '{21, 42, 1}, '{5, 10, 0}
  };

  initial begin
    edge_reg = 7'd16;
    radius_reg = 24'd65536;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) send_point(directed[k].row, directed[k].col, directed[k].typed);
    drain();

    // extremes of size and radius
    foreach (rows_edges[p]) begin
      write_reg(csvg_pkg::REG_GRID_EDGE, 24'(rows_edges[p]));
      write_reg(csvg_pkg::REG_RADIUS, radii[p]);
      send_point(6'd0, 6'd0);
      send_point(6'd63, 6'd63);
      send_point(6'd1, 6'd0);
      if (p == 2) begin
        // long stall with sender still offering
        hold_off <= 400;
        repeat (6) send_point(6'($urandom_range(63)), 6'($urandom_range(63)));
      end
      drain();
    end

    for (int ph = 0; ph < 5; ph++) begin
      int n_eff;
      write_reg(csvg_pkg::REG_GRID_EDGE,
                24'((ph == 4) ? $urandom_range(127) : $urandom_range(64, 2)));
      write_reg(csvg_pkg::REG_RADIUS, 24'($urandom));
      n_eff = (edge_reg < csvg_pkg::MIN_GRID_EDGE) ? csvg_pkg::MIN_GRID_EDGE :
              ((edge_reg > csvg_pkg::MAX_GRID_EDGE) ? csvg_pkg::MAX_GRID_EDGE : edge_reg);
      send_idle = (ph != 2);
      recv_idle = (ph != 2);
      for (int k = 0; k < N_RAND / 5; k++) begin
        if ($urandom_range(9) < 8)
          send_point(6'($urandom_range(n_eff - 1)), 6'($urandom_range(n_eff - 1)));
        else
          send_point(6'($urandom_range(63)), 6'($urandom_range(63)));
      end
      drain();
      send_idle = 1'b1;
      recv_idle = 1'b1;
    end

    $display("sent %0d grid points over several sizes and radii, checked %0d vertices",
             points_sent, vertices_seen);
    if (errors == 0 && pending_vertices.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/csvg_pkg.sv
hw/rtl/csvg_if.sv
hw/rtl/csvg_queue.sv
hw/rtl/csvg_front.sv
hw/rtl/csvg_back.sv
hw/rtl/csvg_emit.sv
hw/rtl/cube_sphere_vertex_gen_top.sv
hw/rtl/csvg_checker.sv
bench/csvg_tb_if.sv
bench/cube_sphere_vertex_gen_top_tb.sv
